@@ sv/tfbf_pkg.sv @@
package tfbf_pkg;

    localparam int unsigned XLEN = 32;
    localparam int unsigned HLEN = 16;

    localparam logic OP_FETCH = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    localparam logic [1:0] ST_FETCHED = 2'd0;
    localparam logic [1:0] ST_HAZARD  = 2'd1;
    localparam logic [1:0] ST_ARM     = 2'd2;
    localparam logic [1:0] ST_FLUSHED = 2'd3;

    localparam logic [1:0] CFG_HAZARD_ADDR = 2'd0;
    localparam logic [1:0] CFG_HAZARD_INST = 2'd1;
    localparam logic [1:0] CFG_BUBBLE_ADDR = 2'd2;
    localparam logic [1:0] CFG_NOP_INST    = 2'd3;

    localparam logic [XLEN-1:0] HAZARD_LIMIT = 32'hF000_0000;
    localparam logic [XLEN-1:0] BT4_ONES     = 32'hF000_9000;
    localparam logic [XLEN-1:0] BT4_ZEROS    = 32'h0800_4000;
    localparam logic [XLEN-1:0] BL_ONES      = 32'hF000_D000;
    localparam logic [XLEN-1:0] BL_ZEROS     = 32'h0800_0000;
    localparam logic [XLEN-1:0] BT2_ONES     = 32'h0000_E000;
    localparam logic [XLEN-1:0] BT2_ZEROS    = 32'h0000_1000;
    localparam logic [XLEN-1:0] BX_ONES      = 32'h0000_4700;
    localparam logic [XLEN-1:0] BX_ZEROS     = 32'h0000_B880;
    localparam logic [XLEN-1:0] ALIGN_MASK   = 32'hFFFF_FFFE;

    typedef struct packed {
        logic [XLEN-1:0] hazard_addr;
        logic [XLEN-1:0] hazard_inst;
        logic [XLEN-1:0] bubble_addr;
        logic [XLEN-1:0] nop_inst;
    } t_cfg;

    typedef struct packed {
        logic [XLEN-1:0] stage_pc;
        logic [XLEN-1:0] stage_inst;
        logic [XLEN-1:0] next_pc;
        logic [1:0]      status;
    } t_result;

    function automatic logic bits_match(input logic [XLEN-1:0] w,
                                        input logic [XLEN-1:0] ones,
                                        input logic [XLEN-1:0] zeros);
        return ((w & ones) == ones) && ((~w & zeros) == zeros);
    endfunction

endpackage

@@ sv/thumb_fetch_branch_forward_unit.sv @@
// Thumb-2 fetch stage with early branch redirect.
// A transaction is held in the input register, then moves into the output register when it advances.
// Throughput: one transaction per cycle while the output is not stalled; the fetch PC loop closes in the decode stage.
// Reset (synchronous, active low) clears fetch PC, config registers and both valid flags.
// Output stall reaches o_in_stall in the same cycle once both registers hold a transaction.
module thumb_fetch_branch_forward_unit (
    input  logic                      i_clk,
    input  logic                      i_rst_n,

    input  logic                      i_cfg_we,
    input  logic [1:0]                i_cfg_index,
    input  logic [tfbf_pkg::XLEN-1:0] i_cfg_data,

    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic                      i_opcode,
    input  logic [tfbf_pkg::HLEN-1:0] i_first_half,
    input  logic [tfbf_pkg::HLEN-1:0] i_second_half,
    input  logic                      i_thumb_state,
    input  logic [tfbf_pkg::XLEN-1:0] i_branch_reg_value,
    input  logic [tfbf_pkg::XLEN-1:0] i_flush_pc,

    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic [tfbf_pkg::XLEN-1:0] o_stage_pc,
    output logic [tfbf_pkg::XLEN-1:0] o_stage_inst,
    output logic [tfbf_pkg::XLEN-1:0] o_next_fetch_pc,
    output logic [1:0]                o_status
);

    tfbf_pkg::t_cfg            r_cfg;
    logic [tfbf_pkg::XLEN-1:0] r_fetch_pc;

    logic                      r_in_valid;
    logic                      r_in_opcode;
    logic [tfbf_pkg::HLEN-1:0] r_in_first_half;
    logic [tfbf_pkg::HLEN-1:0] r_in_second_half;
    logic                      r_in_thumb;
    logic [tfbf_pkg::XLEN-1:0] r_in_reg_value;
    logic [tfbf_pkg::XLEN-1:0] r_in_flush_pc;

    logic                      r_out_valid;
    tfbf_pkg::t_result         r_out;
    tfbf_pkg::t_result         n_out;

    logic                      in_accept;
    logic                      advance;

    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;
    assign in_accept  = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                tfbf_pkg::CFG_HAZARD_ADDR: r_cfg.hazard_addr <= i_cfg_data;
                tfbf_pkg::CFG_HAZARD_INST: r_cfg.hazard_inst <= i_cfg_data;
                tfbf_pkg::CFG_BUBBLE_ADDR: r_cfg.bubble_addr <= i_cfg_data;
                tfbf_pkg::CFG_NOP_INST:    r_cfg.nop_inst    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_opcode      <= i_opcode;
            r_in_first_half  <= i_first_half;
            r_in_second_half <= i_second_half;
            r_in_thumb       <= i_thumb_state;
            r_in_reg_value   <= i_branch_reg_value;
            r_in_flush_pc    <= i_flush_pc;
        end
    end

    tfbf_decode u_decode (
        .i_opcode           (r_in_opcode),
        .i_first_half       (r_in_first_half),
        .i_second_half      (r_in_second_half),
        .i_thumb_state      (r_in_thumb),
        .i_branch_reg_value (r_in_reg_value),
        .i_flush_pc         (r_in_flush_pc),
        .i_fetch_pc         (r_fetch_pc),
        .i_cfg              (r_cfg),
        .o_result           (n_out)
    );

    // fetch PC moves together with the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fetch_pc  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (advance) begin
                r_fetch_pc  <= n_out.next_pc;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_stage_pc      = r_out.stage_pc;
    assign o_stage_inst    = r_out.stage_inst;
    assign o_next_fetch_pc = r_out.next_pc;
    assign o_status        = r_out.status;

    a_pc_tracks_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> r_out.next_pc == r_fetch_pc)
        else $error("fetch PC diverged from pending result");

    a_flush_loads_pc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && r_in_opcode == tfbf_pkg::OP_FLUSH |=> r_fetch_pc == $past(r_in_flush_pc))
        else $error("flush did not load fetch PC");

    a_full_accept_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept && r_in_valid |-> advance)
        else $error("input register overwritten without draining");

    a_advance_fills_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> r_out_valid)
        else $error("result lost after advance");

endmodule

@@ sv/tfbf_decode.sv @@
module tfbf_decode (
    input  logic                         i_opcode,
    input  logic [tfbf_pkg::HLEN-1:0]    i_first_half,
    input  logic [tfbf_pkg::HLEN-1:0]    i_second_half,
    input  logic                         i_thumb_state,
    input  logic [tfbf_pkg::XLEN-1:0]    i_branch_reg_value,
    input  logic [tfbf_pkg::XLEN-1:0]    i_flush_pc,
    input  logic [tfbf_pkg::XLEN-1:0]    i_fetch_pc,
    input  tfbf_pkg::t_cfg               i_cfg,
    output tfbf_pkg::t_result            o_result
);

    logic [tfbf_pkg::XLEN-1:0] base;
    logic [tfbf_pkg::XLEN-1:0] wide_word;
    logic [tfbf_pkg::XLEN-1:0] narrow_word;
    logic [tfbf_pkg::XLEN-1:0] wide_off;
    logic [tfbf_pkg::XLEN-1:0] narrow_off;
    logic                      is_wide;
    logic                      s_bit;
    logic                      i1;
    logic                      i2;

    assign base        = i_fetch_pc + 32'd4;
    assign wide_word   = {i_first_half, i_second_half};
    assign narrow_word = {16'h0000, i_first_half};
    assign is_wide     = i_first_half[15:11] inside {5'b11101, 5'b11110, 5'b11111};

    // S comes from bit 26; J1/J2 fold into I1/I2
    assign s_bit    = wide_word[26];
    assign i1       = ~(wide_word[13] ^ s_bit);
    assign i2       = ~(wide_word[11] ^ s_bit);
    assign wide_off = {{8{s_bit}}, i1, i2, wide_word[25:16], wide_word[10:0], 1'b0};
    assign narrow_off = {{20{narrow_word[10]}}, narrow_word[10:0], 1'b0};

    always_comb begin
        o_result = '0;
        if (i_opcode == tfbf_pkg::OP_FLUSH) begin
            o_result.stage_pc   = i_cfg.bubble_addr;
            o_result.stage_inst = i_cfg.nop_inst;
            o_result.next_pc    = i_flush_pc;
            o_result.status     = tfbf_pkg::ST_FLUSHED;
        end else if (i_fetch_pc > tfbf_pkg::HAZARD_LIMIT) begin
            o_result.stage_pc   = i_cfg.hazard_addr;
            o_result.stage_inst = i_cfg.hazard_inst;
            o_result.next_pc    = i_cfg.hazard_addr;
            o_result.status     = tfbf_pkg::ST_HAZARD;
        end else if (!i_thumb_state) begin
            o_result.next_pc = i_fetch_pc;
            o_result.status  = tfbf_pkg::ST_ARM;
        end else begin
            o_result.stage_pc = base;
            o_result.status   = tfbf_pkg::ST_FETCHED;
            if (is_wide) begin
                o_result.stage_inst = wide_word;
                if (tfbf_pkg::bits_match(wide_word, tfbf_pkg::BT4_ONES, tfbf_pkg::BT4_ZEROS) ||
                    tfbf_pkg::bits_match(wide_word, tfbf_pkg::BL_ONES, tfbf_pkg::BL_ZEROS)) begin
                    o_result.next_pc = base + wide_off;
                end else begin
                    o_result.next_pc = base;
                end
            end else begin
                o_result.stage_inst = narrow_word;
                if (tfbf_pkg::bits_match(narrow_word, tfbf_pkg::BT2_ONES,
                                         tfbf_pkg::BT2_ZEROS)) begin
                    o_result.next_pc = base + narrow_off;
                end else if (tfbf_pkg::bits_match(narrow_word, tfbf_pkg::BX_ONES,
                                                  tfbf_pkg::BX_ZEROS)) begin
                    o_result.next_pc = i_branch_reg_value & tfbf_pkg::ALIGN_MASK;
                end else begin
                    o_result.next_pc = i_fetch_pc + 32'd2;
                end
            end
        end
    end

endmodule
